// ===== hw/rtl/tplq_pkg.sv =====
// tplq_pkg: shared types and codes of the three-level priority queue
// no dependencies; imported by the queue top level and its checker
`default_nettype none

package tplq_pkg;

  localparam int unsigned TAG_PORT_W = 16;
  localparam int unsigned OCC_W      = 7;
  localparam int unsigned NUM_CLASS  = 3;

  typedef logic [1:0] code2_t;

  // item mode codes
  localparam code2_t MODE_PUT = 2'd0;
  localparam code2_t MODE_POP = 2'd1;
  localparam code2_t MODE_ACC = 2'd2;

  // class codes
  localparam code2_t CLS_LOW    = 2'd0;
  localparam code2_t CLS_NORMAL = 2'd1;
  localparam code2_t CLS_HIGH   = 2'd2;

  // result status codes
  localparam code2_t STATUS_OK    = 2'd0;
  localparam code2_t STATUS_EMPTY = 2'd1;
  localparam code2_t STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_POP,
    OP_ACC
  } op_e;

endpackage

`default_nettype wire

// ===== hw/rtl/three_level_priority_queue_accel.sv =====
// three_level_priority_queue_accel: top level of the three-class linked-list queue
// depends on tplq_pkg and tplq_ram (payload store and link store)
//
// usage
//   input channel (in_valid_i / in_ready_o) carries one item: mode_i, level_i, tag_i
//   mode put appends tag_i to class level_i, pop removes the oldest entry of the
//   highest non-empty class, accelerate splices the whole low list onto high
//   output channel (out_valid_o / out_ready_i) returns one result for every item:
//   tag_out_o, tag_valid_o, status_o and occupancy_o after the item
//   each item is accepted in the idle state, which issues the read of the link
//   and payload stores; the execute state uses the registered read data, writes
//   back and loads the result register; a new item is taken only in the idle state
//   the result register loads as the execute state finishes, and the result is
//   offered from that register
//   after reset an init pass writes every entry of the link store to build the
//   free chain; in_ready_o stays low during that pass
//   if the receiver stalls with a result pending, the next item waits in the
//   execute state until the result register frees up, so nothing is lost
`default_nettype none

module three_level_priority_queue_accel #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       mode_i,
  input  wire logic [1:0]                       level_i,
  input  wire logic [tplq_pkg::TAG_PORT_W-1:0]  tag_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [tplq_pkg::TAG_PORT_W-1:0]  tag_out_o,
  output logic                                  tag_valid_o,
  output logic      [1:0]                       status_o,
  output logic      [tplq_pkg::OCC_W-1:0]       occupancy_o
);

  import tplq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // control state
  state_e          state_q, state_d;
  logic [AW-1:0]   init_idx_q, init_idx_d;
  logic            out_valid_q, out_valid_d;

  // list heads, tails and counts, free list head, total fill
  logic [AW-1:0]   head_q [NUM_CLASS];
  logic [AW-1:0]   head_d [NUM_CLASS];
  logic [AW-1:0]   tail_q [NUM_CLASS];
  logic [AW-1:0]   tail_d [NUM_CLASS];
  logic [CW-1:0]   cnt_q  [NUM_CLASS];
  logic [CW-1:0]   cnt_d  [NUM_CLASS];
  logic [AW-1:0]   free_head_q, free_head_d;
  logic [CW-1:0]   occ_q, occ_d;

  // latched item
  op_e             op_q, op_d;
  logic [1:0]      cls_q, cls_d;
  logic [1:0]      ist_q, ist_d;
  logic [TAG_WIDTH-1:0] tag_q, tag_d;

  // result register
  logic [TAG_PORT_W-1:0] tag_out_q, tag_out_d;
  logic            tag_valid_q, tag_valid_d;
  logic [1:0]      status_q, status_d;
  logic [OCC_W-1:0] occupancy_q, occupancy_d;

  // memory ports
  logic            link_we, link_re, pay_we, pay_re;
  logic [AW-1:0]   link_waddr, link_raddr, pay_waddr, pay_raddr;
  logic [AW-1:0]   link_wdata, link_rdata;
  logic [TAG_WIDTH-1:0] pay_rdata;

  logic            accept, go;
  logic [1:0]      pop_cls;
  logic            full;

  assign accept = in_valid_i && in_ready_o;
  // execute state may finish only once the result register is free
  assign go     = !out_valid_q || out_ready_i;
  assign full   = (occ_q == CW'(DEPTH));

  // class that a pop would take from
  always_comb begin
    if (cnt_q[CLS_HIGH] != '0) begin
      pop_cls = CLS_HIGH;
    end else if (cnt_q[CLS_NORMAL] != '0) begin
      pop_cls = CLS_NORMAL;
    end else begin
      pop_cls = CLS_LOW;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_idx_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready_o  = 1'b0;
    init_idx_d  = init_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    free_head_d = free_head_q;
    occ_d       = occ_q;
    op_d        = op_q;
    cls_d       = cls_q;
    ist_d       = ist_q;
    tag_d       = tag_q;
    tag_out_d   = tag_out_q;
    tag_valid_d = tag_valid_q;
    status_d    = status_q;
    occupancy_d = occupancy_q;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    link_re     = 1'b0;
    link_raddr  = '0;
    pay_we      = 1'b0;
    pay_waddr   = '0;
    pay_re      = 1'b0;
    pay_raddr   = '0;

    case (state_q)
      ST_INIT: begin
        // free chain: entry i links to i+1, the last back to entry zero
        link_we    = 1'b1;
        link_waddr = init_idx_q;
        link_wdata = (init_idx_q == AW'(DEPTH - 1)) ? '0 : init_idx_q + 1'b1;
        init_idx_d = init_idx_q + 1'b1;
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          tag_d = TAG_WIDTH'(tag_i);
          cls_d = level_i;
          ist_d = STATUS_OK;
          op_d  = OP_NONE;
          case (mode_i)
            MODE_PUT: begin
              if (level_i != 2'd3) begin
                if (full) begin
                  ist_d = STATUS_FULL;
                end else begin
                  op_d = OP_PUT;
                end
              end
            end
            MODE_POP: begin
              cls_d = pop_cls;
              if (occ_q == '0) begin
                ist_d = STATUS_EMPTY;
              end else begin
                op_d = OP_POP;
              end
            end
            MODE_ACC: begin
              if (cnt_q[CLS_LOW] != '0) begin
                op_d = OP_ACC;
              end
            end
            default: op_d = OP_NONE;
          endcase
          // put needs the next free link, pop the link and tag of the head
          link_re    = 1'b1;
          link_raddr = (mode_i == MODE_POP) ? head_q[pop_cls] : free_head_q;
          pay_re     = 1'b1;
          pay_raddr  = head_q[pop_cls];
        end
      end

      ST_EXEC: begin
        if (go) begin
          out_valid_d = 1'b1;
          tag_out_d   = '0;
          tag_valid_d = 1'b0;
          status_d    = ist_q;
          case (op_q)
            OP_PUT: begin
              free_head_d = link_rdata;
              pay_we      = 1'b1;
              pay_waddr   = free_head_q;
              if (cnt_q[cls_q] == '0) begin
                head_d[cls_q] = free_head_q;
              end else begin
                link_we    = 1'b1;
                link_waddr = tail_q[cls_q];
                link_wdata = free_head_q;
              end
              tail_d[cls_q] = free_head_q;
              cnt_d[cls_q]  = cnt_q[cls_q] + 1'b1;
              occ_d         = occ_q + 1'b1;
            end
            OP_POP: begin
              tag_out_d     = TAG_PORT_W'(pay_rdata);
              tag_valid_d   = 1'b1;
              head_d[cls_q] = link_rdata;
              cnt_d[cls_q]  = cnt_q[cls_q] - 1'b1;
              // freed entry goes to the front of the free list
              link_we       = 1'b1;
              link_waddr    = head_q[cls_q];
              link_wdata    = free_head_q;
              free_head_d   = head_q[cls_q];
              occ_d         = occ_q - 1'b1;
            end
            OP_ACC: begin
              if (cnt_q[CLS_HIGH] == '0) begin
                head_d[CLS_HIGH] = head_q[CLS_LOW];
              end else begin
                link_we    = 1'b1;
                link_waddr = tail_q[CLS_HIGH];
                link_wdata = head_q[CLS_LOW];
              end
              tail_d[CLS_HIGH] = tail_q[CLS_LOW];
              cnt_d[CLS_HIGH]  = cnt_q[CLS_HIGH] + cnt_q[CLS_LOW];
              cnt_d[CLS_LOW]   = '0;
              head_d[CLS_LOW]  = '0;
              tail_d[CLS_LOW]  = '0;
            end
            default: begin
              tag_out_d = '0;
            end
          endcase
          occupancy_d = OCC_W'(occ_d);
        end
      end

      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_idx_q  <= '0;
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      occ_q       <= '0;
      op_q        <= OP_NONE;
      for (int i = 0; i < NUM_CLASS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      init_idx_q  <= init_idx_d;
      out_valid_q <= out_valid_d;
      free_head_q <= free_head_d;
      occ_q       <= occ_d;
      op_q        <= op_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cls_q       <= cls_d;
    ist_q       <= ist_d;
    tag_q       <= tag_d;
    tag_out_q   <= tag_out_d;
    tag_valid_q <= tag_valid_d;
    status_q    <= status_d;
    occupancy_q <= occupancy_d;
  end

  tplq_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  tplq_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (DEPTH)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (tag_q),
    .re_i    (pay_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign tag_out_o   = tag_out_q;
  assign tag_valid_o = tag_valid_q;
  assign status_o    = status_q;
  assign occupancy_o = occupancy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tplq_ram.sv =====
// tplq_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module tplq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tplq_checker.sv =====
// tplq_checker: port-level assertions for the three-level priority queue
// depends on tplq_pkg; bound to three_level_priority_queue_accel
`default_nettype none

module tplq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic [1:0]                       mode_i,
  input wire logic [1:0]                       level_i,
  input wire logic [tplq_pkg::TAG_PORT_W-1:0]  tag_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [tplq_pkg::TAG_PORT_W-1:0]  tag_out_o,
  input wire logic                             tag_valid_o,
  input wire logic [1:0]                       status_o,
  input wire logic [tplq_pkg::OCC_W-1:0]       occupancy_o
);

  import tplq_pkg::*;

  // stalled item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(mode_i) && $stable(level_i)
      && $stable(tag_i))
    else $error("input item changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tag_out_o)
      && $stable(tag_valid_o) && $stable(status_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // a popped entry leaves at least one free slot behind
  a_popped_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tag_valid_o |-> status_o == STATUS_OK && occupancy_o < OCC_W'(DEPTH))
    else $error("popped entry with bad status");

  a_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tag_valid_o |-> tag_out_o == '0)
    else $error("tag shown without a popped entry");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> occupancy_o == OCC_W'(DEPTH))
    else $error("put dropped while store not full");

endmodule

bind three_level_priority_queue_accel tplq_checker #(.DEPTH(DEPTH)) u_tplq_checker (.*);

`default_nettype wire
